// ----- src/xtea_pkg.sv -----
// Shared types, constants and helper functions for the XTEA pipeline.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

	localparam int WORD_W = 32;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [KEY_WORDS-1:0] key_t;

	// One item in flight between two half-round stages
	typedef struct packed {
		logic  valid;
		logic  dec;
		word_t left;
		word_t right;
	} stage_t;

	// Round sum after n additions of the delta, modulo 2^32
	function automatic word_t acc_at(input int n);
		logic [63:0] prod;
		prod = 64'(n) * 64'(DELTA);
		return prod[WORD_W-1:0];
	endfunction

	// Shift-xor-add mixing of one word
	function automatic word_t mix_word(input word_t w);
		return ((w << 4) ^ (w >> 5)) + w;
	endfunction

endpackage

`default_nettype wire

// ----- src/xtea_block_cipher.sv -----
// Top level of the pipelined XTEA ECB block cipher.
//
//   channel   signals                                         direction
//   command   start, busy, decrypt, block_high, block_low     in (busy out)
//   result    done, out_high, out_low                         out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data       in (ready out)
//
// One item is accepted every cycle, and each half-round is one register stage.
// The half-round adder chain sets the clock; busy never rises.
// Reset clears the key words and all stage valid bits.
// The receiver cannot stall, so done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher
	import xtea_pkg::*;
#(
	parameter int CYCLES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 decrypt,
	input  wire logic [WORD_W-1:0]    block_high,
	input  wire logic [WORD_W-1:0]    block_low,
	output logic                      done,
	output logic [WORD_W-1:0]         out_high,
	output logic [WORD_W-1:0]         out_low,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	localparam int STAGES = 2 * CYCLES;

	key_t   key;
	stage_t stage [STAGES+1];

	xtea_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// Pipeline always has room for a new item
	assign busy = 1'b0;

	// Feed the command into the first stage
	assign stage[0] = '{valid: start && !busy, dec: decrypt, left: block_high, right: block_low};

	// Chain the half-round stages
	for (genvar h = 0; h < STAGES; h++) begin : g_half
		localparam int R = h / 2;
		localparam bit IS_ODD = (h % 2) == 1;
		localparam word_t ACC_E = acc_at(IS_ODD ? R + 1 : R);
		localparam word_t ACC_D = acc_at(IS_ODD ? CYCLES - R - 1 : CYCLES - R);

		xtea_half_round #(
			.ODD   (IS_ODD),
			.ACC_E (ACC_E),
			.ACC_D (ACC_D)
		) u_half (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key),
			.stage_in  (stage[h]),
			.stage_out (stage[h+1])
		);
	end

	// Drive the result straight from the last stage register
	assign done     = stage[STAGES].valid;
	assign out_high = stage[STAGES].left;
	assign out_low  = stage[STAGES].right;

	// Every accepted item yields a result after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(STAGES) done)
		else $error("accepted item produced no result on time");

	// No result without an accepted item at the matching cycle
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, STAGES))
		else $error("result without matching item");

	// A key write to word 2 lands in that word
	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_KEY2) |=> key[2] == $past(cfg_data))
		else $error("key word write lost");

	// Key words hold when no write is taken
	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready) |=> $stable(key))
		else $error("key changed without a write");

endmodule

`default_nettype wire

// ----- src/xtea_key_regs.sv -----
// Key register file written through the configuration channel.
`timescale 1ns / 1ps
`default_nettype none

module xtea_key_regs
	import xtea_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire word_t                cfg_data,
	output key_t                      key
);

	key_t key_q;

	// Always take a write
	assign cfg_ready = 1'b1;
	assign key = key_q;

	// Store the addressed key word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/xtea_half_round.sv -----
// One registered XTEA half-round serving both encryption and decryption.
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round
	import xtea_pkg::*;
#(
	parameter bit    ODD   = 1'b0,
	parameter word_t ACC_E = '0,
	parameter word_t ACC_D = '0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire key_t   key,
	input  wire stage_t stage_in,
	output stage_t      stage_out
);

	// Key word selection is fixed per stage and direction
	localparam logic [1:0] SEL_E = ODD ? ACC_E[12:11] : ACC_E[1:0];
	localparam logic [1:0] SEL_D = ODD ? ACC_D[1:0] : ACC_D[12:11];

	logic   valid_s1;
	logic   dec_s1;
	word_t  left_s1;
	word_t  right_s1;
	logic   upd_left;
	word_t  src;
	word_t  mixed;
	word_t  acc_sel;
	word_t  key_sel;
	word_t  tweak;
	word_t  target;
	word_t  updated;

	// Pick the word to update and form the round term
	always_comb begin
		upd_left = (stage_in.dec == ODD);
		src      = upd_left ? stage_in.right : stage_in.left;
		target   = upd_left ? stage_in.left : stage_in.right;
		mixed    = mix_word(src);
		acc_sel  = stage_in.dec ? ACC_D : ACC_E;
		key_sel  = stage_in.dec ? key[SEL_D] : key[SEL_E];
		tweak    = mixed ^ (acc_sel + key_sel);
		updated  = stage_in.dec ? (target - tweak) : (target + tweak);
	end

	// Advance valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		dec_s1   <= stage_in.dec;
		left_s1  <= upd_left ? updated : stage_in.left;
		right_s1 <= upd_left ? stage_in.right : updated;
	end

	assign stage_out = '{valid: valid_s1, dec: dec_s1, left: left_s1, right: right_s1};

endmodule

`default_nettype wire

// ----- bench/xtea_block_cipher_tb.sv -----
// Self-checking testbench for the XTEA ECB block cipher: key loads, block items, result checks.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher_tb;
	import xtea_pkg::*;

	localparam int ROUNDS = 32;
	localparam int LATENCY = 2 * ROUNDS;
	localparam int MAX_REPORTS = 10;
	localparam int KEY_PHASE_ITEMS = 110;
	localparam logic [CFG_IDX_W-1:0] KEY_REGS [KEY_WORDS] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

	typedef struct packed {
		word_t high;
		word_t low;
	} block_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 decrypt;
	logic [WORD_W-1:0]    block_high;
	logic [WORD_W-1:0]    block_low;
	logic                 done;
	logic [WORD_W-1:0]    out_high;
	logic [WORD_W-1:0]    out_low;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// Key copy used by the predictor, and blocks still owed by the cipher
	word_t  key_model [KEY_WORDS] = '{default: '0};
	block_t pending_blocks [$];
	block_t last_result = '0;
	logic   last_dec = 1'b0;
	bit     gaps_on = 1'b1;

	int n_encrypt = 0;
	int n_decrypt = 0;
	int n_key_sets = 0;
	int n_checked = 0;
	int n_mismatch = 0;

	xtea_block_cipher #(
		.CYCLES(ROUNDS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.decrypt   (decrypt),
		.block_high(block_high),
		.block_low (block_low),
		.done      (done),
		.out_high  (out_high),
		.out_low   (out_low),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the cipher hangs
	initial begin
		#2_000_000;
		$display("timeout: %0d blocks still pending", pending_blocks.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Shift-xor-add mix of one half block
	function automatic word_t feistel_mix(input word_t w);
		return ((w << 4) ^ (w >> 5)) + w;
	endfunction

	// Run the full round schedule on one block with the current key
	function automatic block_t xtea_predict(input logic dec, input block_t blk);
		word_t v0;
		word_t v1;
		word_t sum;
		v0 = blk.high;
		v1 = blk.low;
		if (!dec) begin
			sum = '0;
			for (int r = 0; r < ROUNDS; r++) begin
				v0 += feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
				sum += DELTA;
				v1 += feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
			end
		end else begin
			// decryption starts from the sum after all rounds, wrapped to 32 bits
			sum = word_t'(64'(ROUNDS) * 64'(DELTA));
			for (int r = 0; r < ROUNDS; r++) begin
				v1 -= feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
				sum -= DELTA;
				v0 -= feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
			end
		end
		return '{high: v0, low: v1};
	endfunction

	function automatic word_t random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic void log_mismatch(input string what, input word_t want, input word_t got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
	endfunction

	// Present one item, hold it until accepted, then queue its prediction
	task automatic send_block(input logic dec, input word_t high, input word_t low);
		block_t result;
		start <= 1'b1;
		decrypt <= dec;
		block_high <= high;
		block_low <= low;
		do @(posedge clk); while (busy);
		result = xtea_predict(dec, '{high: high, low: low});
		pending_blocks.push_back(result);
		last_result = result;
		last_dec = dec;
		if (dec)
			n_decrypt++;
		else
			n_encrypt++;
	endtask

	// Drop start for a random burst, with noise on the idle fields
	task automatic sender_gap();
		int n;
		if (!gaps_on || $urandom_range(0, 3) != 0)
			return;
		n = $urandom_range(1, 12);
		start <= 1'b0;
		decrypt <= 1'($urandom);
		block_high <= $urandom;
		block_low <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	// Hold off new items until every pending result has come back
	task automatic wait_for_drain();
		start <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four key words while the cipher is idle
	task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		word_t words [KEY_WORDS];
		words = '{k0, k1, k2, k3};
		wait_for_drain();
		for (int i = 0; i < KEY_WORDS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= KEY_REGS[i];
			cfg_data <= words[i];
			do @(posedge clk); while (!cfg_ready);
			key_model[KEY_REGS[i]] = words[i];
		end
		cfg_valid <= 1'b0;
		n_key_sets++;
	endtask

	// Random items; about a quarter undo the previous item to exercise round trips
	task automatic random_blocks(input int count, input bit allow_gaps);
		gaps_on = allow_gaps;
		for (int i = 0; i < count; i++) begin
			if (allow_gaps && $urandom_range(0, 39) == 0)
				gaps_on = !gaps_on;
			if ($urandom_range(0, 3) == 0)
				send_block(!last_dec, last_result.high, last_result.low);
			else
				send_block(1'($urandom_range(0, 1)), random_word(), random_word());
			sender_gap();
		end
	endtask

	// Key left at its reset value
	task automatic test_reset_key();
		send_block(1'b0, '0, '0);
		send_block(1'b1, '0, '0);
		send_block(1'b0, '1, '1);
		send_block(1'b1, '1, '1);
	endtask

	// Field extremes and both directions under fixed keys
	task automatic test_directed_blocks();
		load_key('1, '1, '1, '1);
		send_block(1'b0, '0, '0);
		send_block(1'b1, '0, '0);
		send_block(1'b0, '1, '1);
		send_block(1'b1, '1, '1);
		send_block(1'b0, 32'h8000_0000, 32'h0000_0001);
		send_block(1'b1, 32'h0000_0001, 32'h8000_0000);
		send_block(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
		send_block(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
		load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
		send_block(1'b0, 32'h4142_4344, 32'h4546_4748);
		send_block(1'b1, last_result.high, last_result.low);
		send_block(1'b1, 32'h4142_4344, 32'h4546_4748);
		send_block(1'b0, last_result.high, last_result.low);
	endtask

	// Random traffic under a series of keys, extremes first
	task automatic test_key_sweep();
		load_key('1, '0, '1, '0);
		random_blocks(KEY_PHASE_ITEMS, 1'b1);
		load_key('0, '1, '0, '1);
		random_blocks(KEY_PHASE_ITEMS, 1'b1);
		load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		random_blocks(KEY_PHASE_ITEMS, 1'b1);
		repeat (3) begin
			load_key($urandom, $urandom, $urandom, $urandom);
			random_blocks(KEY_PHASE_ITEMS, 1'b1);
		end
	endtask

	// Let the pipeline empty completely mid-stream, then resume
	task automatic test_pause_until_empty();
		random_blocks(20, 1'b1);
		wait_for_drain();
		random_blocks(20, 1'b1);
	endtask

	// Back-to-back items with no gaps at all
	task automatic test_back_to_back();
		load_key($urandom, $urandom, $urandom, $urandom);
		random_blocks(60, 1'b0);
	endtask

	// Compare each strobed result with the oldest pending block
	always @(posedge clk) begin
		block_t want;
		if (arst_n && done) begin
			if (pending_blocks.size() == 0) begin
				log_mismatch("result with nothing pending, high word", '0, out_high);
			end else begin
				want = pending_blocks.pop_front();
				n_checked++;
				if (out_high !== want.high)
					log_mismatch("out_high", want.high, out_high);
				if (out_low !== want.low)
					log_mismatch("out_low", want.low, out_low);
			end
		end
	end

	initial begin
		int drain_cycles;
		arst_n <= 1'b0;
		start <= 1'b0;
		decrypt <= 1'b0;
		block_high <= '0;
		block_low <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KEY0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_directed_blocks();
		test_key_sweep();
		test_pause_until_empty();
		test_back_to_back();

		// Drain, then watch a while longer for stray results
		start <= 1'b0;
		drain_cycles = 0;
		while (pending_blocks.size() != 0 && drain_cycles < 4 * LATENCY) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (LATENCY + 8) @(posedge clk);
		if (pending_blocks.size() != 0) begin
			$display("%0d expected results never arrived", pending_blocks.size());
			n_mismatch += pending_blocks.size();
		end

		$display("covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads",
			n_encrypt + n_decrypt, n_encrypt, n_decrypt, n_key_sets);
		$display("checked %0d results, %0d mismatches", n_checked, n_mismatch);
		if (n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
